// File: design/lfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared types and constants of the linear field gather block.
// ----------------------------------------------------------------------------
package lfg_pkg;

    localparam int FIELD_W    = 32;
    localparam int POS_W      = 32;
    localparam int NUM_FIELDS = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int NODES_W    = 11;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = FIELD_W + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_NODES = 2'd0,
        CFG_INV_CELL  = 2'd1,
        CFG_WEIGHT    = 2'd2
    } cfg_reg_t;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_GATHER = 1'b1;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef field_t [NUM_FIELDS-1:0] field_vec_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        field_vec_t       f;
    } node_t;

    // item loads into the arithmetic stages
    typedef struct packed {
        logic ld4;
        logic ld5;
        logic ld6;
        logic ld7;
    } stage_ld_t;

endpackage

// File: design/lfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_if
// Request, response and configuration channels of the field gather.
// ----------------------------------------------------------------------------
interface lfg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [9:0]  node_index;
    logic [31:0] node_position;
    logic signed [31:0] node_ex;
    logic signed [31:0] node_ey;
    logic signed [31:0] node_ez;
    logic signed [31:0] node_bz;
    logic signed [31:0] node_by;
    logic [31:0] particle_position;
    logic        last_particle;

    modport source (output valid, req_type, node_index, node_position, node_ex, node_ey,
                    node_ez, node_bz, node_by, particle_position, last_particle,
                    input ready);
    modport sink (input valid, req_type, node_index, node_position, node_ex, node_ey,
                  node_ez, node_bz, node_by, particle_position, last_particle,
                  output ready);
endinterface

interface lfg_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] field_ex;
    logic signed [31:0] field_ey;
    logic signed [31:0] field_ez;
    logic signed [31:0] field_bz;
    logic signed [31:0] field_by;
    logic        wrapped;
    logic        out_of_range;
    logic        last_of_batch;

    modport source (output valid, field_ex, field_ey, field_ez, field_bz, field_by,
                    wrapped, out_of_range, last_of_batch, input ready);
    modport sink (input valid, field_ex, field_ey, field_ez, field_bz, field_by,
                  wrapped, out_of_range, last_of_batch, output ready);
endinterface

interface lfg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/lfg_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfg_interp
// One field component: weighted sum of two nodes, scale, floor and saturate, or zero when asked.
// ----------------------------------------------------------------------------
module lfg_interp (
    input  logic                               clk,
    input  lfg_pkg::stage_ld_t                 ld,
    input  lfg_pkg::field_t                    fl,
    input  lfg_pkg::field_t                    fr,
    input  logic signed [lfg_pkg::DIFF_W-1:0]  dl,
    input  logic signed [lfg_pkg::DIFF_W-1:0]  dr,
    input  logic [31:0]                        weight_scale,
    input  logic                               zero,
    output lfg_pkg::field_t                    result
);
    import lfg_pkg::*;

    localparam int LO_W  = DIFF_W;          // low slice of the sum, unsigned
    localparam int HI_W  = SUM_W - LO_W;    // high slice, signed
    localparam int TOT_W = HI_W + 33 + LO_W;
    localparam int SH_W  = TOT_W - 32;

    logic signed [PROD_W-1:0]    pl_reg, pr_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [HI_W+32:0]     phi_reg;
    logic [LO_W+31:0]            plo_reg;
    field_t                      result_reg;

    logic signed [TOT_W-1:0]     total;
    logic signed [SH_W-1:0]      shifted;
    field_t                      result_next;

    always_ff @(posedge clk)
    begin
        if (ld.ld4)
        begin
            pl_reg <= fl * dl;
            pr_reg <= fr * dr;
        end
        if (ld.ld5)
            sum_reg <= SUM_W'(pl_reg) + SUM_W'(pr_reg);
        if (ld.ld6)
        begin
            phi_reg <= $signed(sum_reg[SUM_W-1:LO_W]) * $signed({1'b0, weight_scale});
            plo_reg <= sum_reg[LO_W-1:0] * weight_scale;
        end
        if (ld.ld7)
            result_reg <= result_next;
    end

    always_comb
    begin
        total   = $signed({phi_reg, {LO_W{1'b0}}}) + $signed({{(TOT_W-LO_W-32){1'b0}}, plo_reg});
        shifted = total[TOT_W-1:32];
        if (zero)
            result_next = '0;
        else if ((&shifted[SH_W-1:FIELD_W-1]) || !(|shifted[SH_W-1:FIELD_W-1]))
            result_next = shifted[FIELD_W-1:0];
        else if (shifted[SH_W-1])
            result_next = {1'b1, {(FIELD_W-1){1'b0}}};
        else
            result_next = {1'b0, {(FIELD_W-1){1'b1}}};
    end

    assign result = result_reg;

endmodule

// File: design/linear_field_gather_1d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_field_gather_1d
// Linear (cloud-in-cell) gather of five field components on a periodic grid.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled, grid writes and
// gathers alike. A gather passes through the input register, cell index
// multiply, grid memory read (two read ports, registered), field by distance
// multiplies, sum, scale multiply in two partial products, then floor,
// saturate and the output register. Each stage holds its item while the one
// after it is full, so bubbles close up and nothing is lost under backpressure.
// A grid write inside the grid is applied at the memory stage and gives no result.
module linear_field_gather_1d #(
    parameter int GRID_NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    lfg_req_if.sink     req,
    lfg_rsp_if.source   rsp,
    lfg_cfg_if.sink     cfg
);
    import lfg_pkg::*;

    localparam int IDX_W = $clog2(GRID_NODES);
    localparam logic [16:0] GRID_N = 17'(GRID_NODES);

    // configuration
    logic [NODES_W-1:0] num_nodes_reg;
    logic [31:0]        inv_cell_reg, weight_reg;

    // pipeline valid bits, stages 1..7 (7 is the output register)
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic go1, go2, go3, go4, go5, go6, go7;
    logic free1, free2, free3, free4, free5, free6, free7;
    logic ld3;
    stage_ld_t ld;

    // stage 1
    logic             type1_reg, last1_reg;
    logic [9:0]       idx1_reg;
    logic [POS_W-1:0] p1_reg;
    node_t            node1_reg;
    // stage 2
    logic             type2_reg, last2_reg;
    logic [9:0]       idx2_reg;
    logic [POS_W-1:0] p2_reg;
    node_t            node2_reg;
    logic [31:0]      li2_reg;
    // stage 3
    logic [POS_W-1:0] p3_reg;
    logic             last3_reg, oor3_reg, wrap3_reg;
    node_t            rdl_reg, rdr_reg;
    // flags 4..7
    logic last4_reg, oor4_reg, wrap4_reg;
    logic last5_reg, oor5_reg, wrap5_reg;
    logic last6_reg, oor6_reg, wrap6_reg;
    logic last7_reg, oor7_reg, wrap7_reg;

    node_t mem [GRID_NODES];

    logic [16:0]       n_eff;
    logic              oor2, wrap2, wr_en;
    logic [32:0]       ri_sum;
    logic [IDX_W-1:0]  li_addr, ri_addr, wr_addr;
    logic signed [DIFF_W-1:0] dl3, dr3;
    field_vec_t        res;

    // handshake chain
    assign go7   = v7_reg && rsp.ready;
    assign free7 = !v7_reg || go7;
    assign go6   = v6_reg && free7;
    assign free6 = !v6_reg || go6;
    assign go5   = v5_reg && free6;
    assign free5 = !v5_reg || go5;
    assign go4   = v4_reg && free5;
    assign free4 = !v4_reg || go4;
    assign go3   = v3_reg && free4;
    assign free3 = !v3_reg || go3;
    assign go2   = v2_reg && ((type2_reg == REQ_WRITE) || free3);
    assign free2 = !v2_reg || go2;
    assign go1   = v1_reg && free2;
    assign free1 = !v1_reg || go1;
    assign req.ready = free1;
    assign ld3    = go2 && (type2_reg == REQ_GATHER);
    assign ld.ld4 = go3;
    assign ld.ld5 = go4;
    assign ld.ld6 = go5;
    assign ld.ld7 = go6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            num_nodes_reg <= NODES_W'(1024);
            inv_cell_reg  <= 32'd65536;
            weight_reg    <= 32'd65536;
        end
        else
        begin
            v1_reg <= (req.valid && free1) || (v1_reg && !go1);
            v2_reg <= go1 || (v2_reg && !go2);
            v3_reg <= ld3 || (v3_reg && !go3);
            v4_reg <= go3 || (v4_reg && !go4);
            v5_reg <= go4 || (v5_reg && !go5);
            v6_reg <= go5 || (v6_reg && !go6);
            v7_reg <= go6 || (v7_reg && !go7);
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    CFG_NUM_NODES: num_nodes_reg <= cfg.data[NODES_W-1:0];
                    CFG_INV_CELL:  inv_cell_reg  <= cfg.data;
                    CFG_WEIGHT:    weight_reg    <= cfg.data;
                    default:       ;
                endcase
            end
        end
    end
    assign cfg.ready = 1'b1;

    // stage 2 control: node indices, range checks and write enable; stage 3 distances
    always_comb
    begin
        n_eff   = ({6'b0, num_nodes_reg} > GRID_N) ? GRID_N : {6'b0, num_nodes_reg};
        oor2    = li2_reg >= {15'b0, n_eff};
        ri_sum  = {1'b0, li2_reg} + 33'd1;
        wrap2   = ri_sum >= {16'b0, n_eff};
        li_addr = IDX_W'(li2_reg);
        ri_addr = wrap2 ? '0 : IDX_W'(ri_sum);
        wr_addr = IDX_W'(idx2_reg);
        wr_en   = v2_reg && (type2_reg == REQ_WRITE) && ({22'b0, idx2_reg} < 32'(GRID_NODES));
        dl3     = $signed({1'b0, rdr_reg.pos}) - $signed({1'b0, p3_reg});
        dr3     = $signed({1'b0, p3_reg}) - $signed({1'b0, rdl_reg.pos});
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && free1)
        begin
            type1_reg   <= req.req_type;
            last1_reg   <= req.last_particle;
            idx1_reg    <= req.node_index;
            p1_reg      <= req.particle_position;
            node1_reg   <= {req.node_position, req.node_by, req.node_bz, req.node_ez,
                            req.node_ey, req.node_ex};
        end
        if (go1)
        begin
            type2_reg <= type1_reg;
            last2_reg <= last1_reg;
            idx2_reg  <= idx1_reg;
            p2_reg    <= p1_reg;
            node2_reg <= node1_reg;
            li2_reg   <= 32'((64'(p1_reg) * 64'(inv_cell_reg)) >> 32);
        end
        if (ld3)
        begin
            p3_reg    <= p2_reg;
            last3_reg <= last2_reg;
            oor3_reg  <= oor2;
            wrap3_reg <= wrap2 && !oor2;
            rdl_reg   <= mem[li_addr];
            rdr_reg   <= mem[ri_addr];
        end
        if (wr_en)
            mem[wr_addr] <= node2_reg;
        if (go3)
        begin
            last4_reg <= last3_reg;
            oor4_reg  <= oor3_reg;
            wrap4_reg <= wrap3_reg;
        end
        if (go4)
        begin
            last5_reg <= last4_reg;
            oor5_reg  <= oor4_reg;
            wrap5_reg <= wrap4_reg;
        end
        if (go5)
        begin
            last6_reg <= last5_reg;
            oor6_reg  <= oor5_reg;
            wrap6_reg <= wrap5_reg;
        end
        if (go6)
        begin
            last7_reg <= last6_reg;
            oor7_reg  <= oor6_reg;
            wrap7_reg <= wrap6_reg;
        end
    end

    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_field
        lfg_interp u_interp (
            .clk          (clk),
            .ld           (ld),
            .fl           (rdl_reg.f[k]),
            .fr           (rdr_reg.f[k]),
            .dl           (dl3),
            .dr           (dr3),
            .weight_scale (weight_reg),
            .zero         (oor6_reg),
            .result       (res[k])
        );
    end

    assign rsp.valid         = v7_reg;
    assign rsp.field_ex      = res[0];
    assign rsp.field_ey      = res[1];
    assign rsp.field_ez      = res[2];
    assign rsp.field_bz      = res[3];
    assign rsp.field_by      = res[4];
    assign rsp.wrapped       = wrap7_reg;
    assign rsp.out_of_range  = oor7_reg;
    assign rsp.last_of_batch = last7_reg;

    // an out-of-range gather gives zero fields and no wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && oor7_reg) |-> (!wrap7_reg && res[0] == '0 && res[4] == '0))
        else $error("out-of-range result not cleared");

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && !rsp.ready) |=> (v7_reg && $stable(res[0]) && $stable(oor7_reg)))
        else $error("stalled result changed");

    // input is refused only while the first stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> v1_reg)
        else $error("input refused with empty first stage");

    // a grid write never leaves the memory stage as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && type2_reg == REQ_WRITE) |-> !ld3)
        else $error("write item entered the arithmetic stages");

endmodule
